/* src/sals_pkg.sv */
// Package with shared types and constants for the sorted-array levels set.
package sals_pkg;
	localparam int KeyW = 32;
	localparam int CountOutW = 11;
	localparam logic [KeyW-1:0] SignFlip = 32'h8000_0000;

	// Function codes of a request.
	localparam logic FuncInsert = 1'b0;
	localparam logic FuncSearch = 1'b1;

	typedef logic [KeyW-1:0] key_t;
endpackage

/* src/sals_mem.sv */
// Single-port memory with registered read data.
module sals_mem #(
	parameter int AddrW = 11
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AddrW-1:0]  addr,
	input  sals_pkg::key_t    wdata,
	output sals_pkg::key_t    rdata
);
	import sals_pkg::*;

	key_t mem [0:(1<<AddrW)-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

/* src/sorted_array_levels_set.sv */
// Top level of the sorted-array levels set: sequencer, shared comparator and stores.
//
// A request is taken when start is high and busy is low; busy then stays high until
// the single result has been shown for one cycle with done high. The receiver cannot
// stall: found, refused_full and stored_count are valid only in the done cycle. Every
// probe of the level store and of the merge buffer is one memory access followed by one
// compare in a single shared unsigned comparator. A search makes binary-search probes in
// each full level in turn until the key is found (level i takes at most i+1 probes, so
// at most (L+1)(L+2)/2 probes when levels 0..L are full). An insert that fills level t
// walks levels 0..t-1, each merge writing 2^(i+1) keys for level i into the merge
// buffer, and then copies 2^t keys into the level store. A refused insert goes straight
// from idle to the done state. No clearing pass is needed: only full levels are read.
module sorted_array_levels_set #(
	parameter int TOP_LEVEL = 10
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              func,
	input  logic signed [sals_pkg::KeyW-1:0]  key_value,
	output logic                              done,
	output logic                              found,
	output logic                              refused_full,
	output logic [sals_pkg::CountOutW-1:0]    stored_count
);
	import sals_pkg::*;

	localparam int AW = TOP_LEVEL + 1;       // address bits of both memories
	localparam int LW = $clog2(TOP_LEVEL + 2);
	localparam int CW = TOP_LEVEL + 1;       // key count width
	localparam int IW = $clog2(CW);          // bit index into the key count

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_SLEVEL = 4'd1;  // pick next full level to search
	localparam logic [3:0] S_SPROBE = 4'd2;  // issue read of the midpoint
	localparam logic [3:0] S_SWAIT  = 4'd3;
	localparam logic [3:0] S_SCMP   = 4'd4;
	localparam logic [3:0] S_MLEVEL = 4'd5;  // set up merge of one level
	localparam logic [3:0] S_MRD    = 4'd6;  // read level and carry tails
	localparam logic [3:0] S_MWAIT  = 4'd7;
	localparam logic [3:0] S_MCMP   = 4'd8;  // compare and write one key
	localparam logic [3:0] S_CRD    = 4'd9;  // copy buffer into level store
	localparam logic [3:0] S_CWR    = 4'd10;
	localparam logic [3:0] S_DONE   = 4'd11;

	logic [3:0]   state_q;
	key_t         key_q;
	logic [CW-1:0] count_q;
	logic [LW-1:0] lvl_q, target_q;
	logic [AW-1:0] lo_q, hi_q, a_q, b_q, i_q;
	logic         found_q, refused_q;

	// Level store and merge buffer ports.
	logic          st_we, bf_we;
	logic [AW-1:0] st_addr, bf_addr;
	key_t          st_wdata, bf_wdata, st_rdata, bf_rdata;

	sals_mem #(.AddrW(AW)) u_store (
		.clk(clk), .we(st_we), .addr(st_addr), .wdata(st_wdata), .rdata(st_rdata)
	);
	sals_mem #(.AddrW(AW)) u_buf (
		.clk(clk), .we(bf_we), .addr(bf_addr), .wdata(bf_wdata), .rdata(bf_rdata)
	);

	logic [AW-1:0] base, mid, span;
	logic          cmp_gt, cmp_eq;
	key_t          cmp_a, cmp_b;
	logic [CW-1:0] full_count;
	logic [LW-1:0] target_d;

	assign full_count = {CW{1'b1}};
	assign span = AW'(1) << lvl_q;
	assign base = span - AW'(1);
	assign mid  = lo_q + ((hi_q - lo_q) >> 1);

	// The level an insert fills is the lowest empty one, or the top level.
	always_comb begin
		target_d = LW'(TOP_LEVEL);
		for (int k = TOP_LEVEL - 1; k >= 0; k--) begin
			if (!count_q[k]) begin
				target_d = LW'(k);
			end
		end
	end

	// The shared comparator: level word against the key or against the carry word.
	always_comb begin
		cmp_a = st_rdata;
		cmp_b = (state_q == S_SCMP) ? key_q : bf_rdata;
	end
	assign cmp_gt = cmp_a > cmp_b;
	assign cmp_eq = cmp_a == cmp_b;

	// Memory control.
	always_comb begin
		st_we = 1'b0;
		bf_we = 1'b0;
		st_addr = base + mid;
		bf_addr = b_q - AW'(1);
		st_wdata = bf_rdata;
		bf_wdata = st_rdata;
		unique case (state_q)
			S_IDLE: begin
				bf_we = start && (func == FuncInsert);
				bf_addr = '0;
				bf_wdata = key_t'(key_value) ^ SignFlip;
			end
			S_MRD, S_MWAIT: begin
				st_addr = base + a_q - AW'(1);
			end
			S_MCMP: begin
				st_addr = base + a_q - AW'(1);
				bf_we = 1'b1;
				bf_addr = a_q + b_q - AW'(1);
				// A carry word stays when the level is used up or not strictly greater.
				bf_wdata = (a_q != '0 && b_q != '0 && cmp_gt) || (b_q == '0)
					? st_rdata : bf_rdata;
			end
			S_CRD: begin
				bf_addr = i_q;
			end
			S_CWR: begin
				bf_addr = i_q;
				st_we = 1'b1;
				st_addr = (AW'(1) << target_q) - AW'(1) + i_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						key_q <= key_t'(key_value) ^ SignFlip;
						found_q <= 1'b0;
						refused_q <= (func == FuncInsert) && (count_q == full_count);
						lvl_q <= '0;
						target_q <= target_d;
						if (func == FuncSearch) begin
							state_q <= S_SLEVEL;
						end else if (count_q == full_count) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_MLEVEL;
						end
					end
				end
				S_SLEVEL: begin
					if (found_q || lvl_q > LW'(TOP_LEVEL)) begin
						state_q <= S_DONE;
					end else if (count_q[lvl_q[IW-1:0]]) begin
						lo_q <= '0;
						hi_q <= span;
						state_q <= S_SPROBE;
					end else begin
						lvl_q <= lvl_q + LW'(1);
					end
				end
				S_SPROBE: begin
					if (lo_q < hi_q) begin
						state_q <= S_SWAIT;
					end else begin
						lvl_q <= lvl_q + LW'(1);
						state_q <= S_SLEVEL;
					end
				end
				S_SWAIT: state_q <= S_SCMP;
				S_SCMP: begin
					if (cmp_eq) begin
						found_q <= 1'b1;
						state_q <= S_DONE;
					end else begin
						if (cmp_gt) hi_q <= mid;
						else lo_q <= mid + AW'(1);
						state_q <= S_SPROBE;
					end
				end
				S_MLEVEL: begin
					if (lvl_q == target_q) begin
						i_q <= '0;
						state_q <= S_CRD;
					end else begin
						a_q <= span;
						b_q <= span;
						state_q <= S_MRD;
					end
				end
				S_MRD: begin
					if (a_q == '0 && b_q == '0) begin
						lvl_q <= lvl_q + LW'(1);
						state_q <= S_MLEVEL;
					end else begin
						state_q <= S_MWAIT;
					end
				end
				S_MWAIT: state_q <= S_MCMP;
				S_MCMP: begin
					if ((a_q != '0 && b_q != '0 && cmp_gt) || (b_q == '0)) begin
						a_q <= a_q - AW'(1);
					end else begin
						b_q <= b_q - AW'(1);
					end
					state_q <= S_MRD;
				end
				S_CRD: state_q <= S_CWR;
				S_CWR: begin
					if (i_q == (AW'(1) << target_q) - AW'(1)) begin
						count_q <= count_q + CW'(1);
						state_q <= S_DONE;
					end else begin
						i_q <= i_q + AW'(1);
						state_q <= S_CRD;
					end
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = state_q == S_DONE;
	assign found = found_q;
	assign refused_full = refused_q;
	assign stored_count = CountOutW'(count_q);

	a_done_one: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(found && refused_full)) else $error("found and refused");
	a_search_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCMP) |=> $stable(count_q)) else $error("count moved in search");
	a_refuse: assert property (@(posedge clk) disable iff (!arst_n)
		(done && refused_full) |-> (count_q == full_count)) else $error("bad refuse");
endmodule
